// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with synchronous reset masking
`define TGAPD_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define TGAPD_NEVER(name, clk, rst, cond, msg) \
  `TGAPD_ASSERT(name, clk, rst, !(cond), msg)

`endif

// ===== rtl/core/tgapd_pkg.sv =====
// ----------------------------------------------------------------------------
// tgapd_pkg
// shared types and register indexes of the tga pixel stream decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgapd_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 13;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RLE_PACKED     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MIRROR_COLUMNS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_TOP_DOWN  = 3'd5;

  // input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  typedef struct packed {
    logic [2:0]  pixel_bytes;
    logic        rle_packed;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        mirror_columns;
    logic        rows_top_down;
  } cfg_t;

  // positioned pixel event from the front end, channels still packed
  typedef struct packed {
    logic [11:0] x_first;
    logic [11:0] y_row;
    logic [7:0]  run_length;
    logic        run_clipped;
    logic        last_pixel;
    logic [2:0]  pix_bytes;
    logic [23:0] held;
    logic [7:0]  data;
  } evt_t;

  typedef struct packed {
    logic [11:0] x_first;
    logic [11:0] y_row;
    logic [7:0]  run_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  luminance;
    logic        run_clipped;
    logic        last_pixel;
  } res_t;

endpackage

// ===== rtl/core/tgapd_fifo.sv =====
// ----------------------------------------------------------------------------
// tgapd_fifo
// small register queue with count based full and empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgapd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/tgapd_front.sv =====
// ----------------------------------------------------------------------------
// tgapd_front
// packet parsing, byte gathering and run positioning, one byte per cycle while take is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgapd_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  tgapd_pkg::cfg_t    cfg,
  input  logic               take,
  input  logic               action,
  input  logic [7:0]         data_byte,
  output logic               evt_valid,
  output tgapd_pkg::evt_t    evt
);
  import tgapd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_RUN,
    PH_RAW,
    PH_DROP
  } phase_t;

  localparam logic [15:0] MAX_W16 = 16'(MAX_WIDTH);
  localparam logic [15:0] MAX_H16 = 16'(MAX_HEIGHT);

  phase_t      packet_phase, packet_phase_next;
  logic [7:0]  packet_left, packet_left_next;
  logic [1:0]  byte_slot, byte_slot_next;
  logic [23:0] held_pixel_bytes, held_pixel_bytes_next;
  logic [12:0] column_count, column_count_next;
  logic [11:0] row_count, row_count_next;
  logic        image_done, image_done_next;
  logic        emit;

  // effective sizes
  logic [2:0]  pb;
  logic [12:0] w;
  logic [12:0] h;

  // run geometry
  logic [7:0]  left_dec;
  logic [7:0]  count;
  logic        raw_more;
  logic [12:0] remain;
  logic [7:0]  len;
  logic [13:0] col_sum;
  logic        row_end;
  logic [12:0] x_full;
  logic [12:0] y_full;
  logic [11:0] row_inc;
  logic        last;
  logic        clipped;

  always_comb begin
    if (cfg.pixel_bytes == 3'd0) begin
      pb = 3'd1;
    end else if (cfg.pixel_bytes > 3'd4) begin
      pb = 3'd4;
    end else begin
      pb = cfg.pixel_bytes;
    end

    if (cfg.image_width == '0) begin
      w = 13'd1;
    end else if ({3'b0, cfg.image_width} > MAX_W16) begin
      w = MAX_W16[12:0];
    end else begin
      w = cfg.image_width;
    end

    if (cfg.image_height == '0) begin
      h = 13'd1;
    end else if ({3'b0, cfg.image_height} > MAX_H16) begin
      h = MAX_H16[12:0];
    end else begin
      h = cfg.image_height;
    end
  end

  always_comb begin
    left_dec = (packet_left != '0) ? packet_left - 8'd1 : '0;
    if (cfg.rle_packed && packet_phase == PH_RUN) begin
      count = (packet_left == '0) ? 8'd1 : packet_left;
    end else begin
      count = 8'd1;
    end
    raw_more = cfg.rle_packed && (packet_phase != PH_RUN) && (left_dec != '0);

    remain  = (column_count < w) ? w - column_count : 13'd1;
    len     = ({5'b0, count} < remain) ? count : remain[7:0];
    col_sum = {1'b0, column_count} + {6'b0, len};
    row_end = (col_sum >= {1'b0, w});
    clipped = ({5'b0, count} > remain) || (row_end && raw_more);
    x_full  = cfg.mirror_columns ? (w - column_count - {5'b0, len}) : column_count;
    y_full  = cfg.rows_top_down ? {1'b0, row_count} : (h - 13'd1 - {1'b0, row_count});
    row_inc = row_count + 12'd1;
    last    = row_end && (({1'b0, row_inc} >= h) || (row_inc == '0));
  end

  always_comb begin
    packet_phase_next     = packet_phase;
    packet_left_next      = packet_left;
    byte_slot_next        = byte_slot;
    held_pixel_bytes_next = held_pixel_bytes;
    column_count_next     = column_count;
    row_count_next        = row_count;
    image_done_next       = image_done;
    emit                  = 1'b0;

    if (take) begin
      if (action == ACT_START) begin
        packet_phase_next     = PH_HEADER;
        packet_left_next      = '0;
        byte_slot_next        = '0;
        held_pixel_bytes_next = '0;
        column_count_next     = '0;
        row_count_next        = '0;
        image_done_next       = 1'b0;
      end else if (!image_done) begin
        if (cfg.rle_packed && packet_phase == PH_HEADER) begin
          packet_phase_next     = data_byte[7] ? PH_RUN : PH_RAW;
          packet_left_next      = {1'b0, data_byte[6:0]} + 8'd1;
          byte_slot_next        = '0;
          held_pixel_bytes_next = '0;
        end else if (({1'b0, byte_slot} + 3'd1) < pb) begin
          case (byte_slot)
            2'd0:    held_pixel_bytes_next = held_pixel_bytes | {16'b0, data_byte};
            2'd1:    held_pixel_bytes_next = held_pixel_bytes | {8'b0, data_byte, 8'b0};
            2'd2:    held_pixel_bytes_next = held_pixel_bytes | {data_byte, 16'b0};
            default: held_pixel_bytes_next = held_pixel_bytes;
          endcase
          byte_slot_next = byte_slot + 2'd1;
        end else begin
          // pixel complete
          byte_slot_next        = '0;
          held_pixel_bytes_next = '0;
          if (!cfg.rle_packed) begin
            emit = 1'b1;
          end else if (packet_phase == PH_RUN) begin
            packet_phase_next = PH_HEADER;
            packet_left_next  = '0;
            emit              = 1'b1;
          end else begin
            packet_left_next = left_dec;
            if (packet_phase == PH_DROP) begin
              if (left_dec == '0) begin
                packet_phase_next = PH_HEADER;
              end
            end else begin
              emit = 1'b1;
              if (left_dec == '0) begin
                packet_phase_next = PH_HEADER;
              end else if (row_end) begin
                packet_phase_next = PH_DROP;
              end
            end
          end
          if (emit) begin
            if (row_end) begin
              column_count_next = '0;
              row_count_next    = row_inc;
              if (last) begin
                image_done_next = 1'b1;
              end
            end else begin
              column_count_next = col_sum[12:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_phase     <= PH_HEADER;
      packet_left      <= '0;
      byte_slot        <= '0;
      held_pixel_bytes <= '0;
      column_count     <= '0;
      row_count        <= '0;
      image_done       <= 1'b1;
    end else begin
      packet_phase     <= packet_phase_next;
      packet_left      <= packet_left_next;
      byte_slot        <= byte_slot_next;
      held_pixel_bytes <= held_pixel_bytes_next;
      column_count     <= column_count_next;
      row_count        <= row_count_next;
      image_done       <= image_done_next;
    end
  end

  assign evt_valid       = emit;
  assign evt.x_first     = x_full[11:0];
  assign evt.y_row       = y_full[11:0];
  assign evt.run_length  = len;
  assign evt.run_clipped = clipped;
  assign evt.last_pixel  = last;
  assign evt.pix_bytes   = pb;
  assign evt.held        = held_pixel_bytes;
  assign evt.data        = data_byte;

endmodule

// ===== rtl/core/tgapd_back.sv =====
// ----------------------------------------------------------------------------
// tgapd_back
// pixel format conversion and luminance for one event per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgapd_back (
  input  tgapd_pkg::evt_t evt,
  output tgapd_pkg::res_t res
);
  import tgapd_pkg::*;

  // multiply by 683 then shift 11 is exact division by 3 below 2048
  localparam logic [9:0] RECIP3 = 10'd683;

  logic [7:0]  c0, c1, c2;
  logic [14:0] s555;
  logic [7:0]  rd, gr, bl, al;
  logic        gray;
  logic [9:0]  sum;
  logic [19:0] prod;

  always_comb begin
    c0   = evt.held[7:0];
    c1   = evt.held[15:8];
    c2   = evt.held[23:16];
    s555 = {evt.data[6:0], c0};
    gray = 1'b0;
    case (evt.pix_bytes)
      3'd1: begin
        gray = 1'b1;
        rd   = evt.data;
        gr   = evt.data;
        bl   = evt.data;
        al   = evt.data;
      end
      3'd2: begin
        rd = {s555[14:10], 3'b0};
        gr = {s555[9:5], 3'b0};
        bl = {s555[4:0], 3'b0};
        al = 8'hFF;
      end
      3'd3: begin
        rd = evt.data;
        gr = c1;
        bl = c0;
        al = 8'hFF;
      end
      default: begin
        rd = c2;
        gr = c1;
        bl = c0;
        al = evt.data;
      end
    endcase
    sum  = {2'b0, rd} + {2'b0, gr} + {2'b0, bl};
    prod = sum * RECIP3;
  end

  assign res.x_first     = evt.x_first;
  assign res.y_row       = evt.y_row;
  assign res.run_length  = evt.run_length;
  assign res.red         = rd;
  assign res.green       = gr;
  assign res.blue        = bl;
  assign res.alpha       = al;
  assign res.luminance   = gray ? evt.data : prod[18:11];
  assign res.run_clipped = evt.run_clipped;
  assign res.last_pixel  = evt.last_pixel;

endmodule

// ===== rtl/core/tga_pixel_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_core
// tga pixel data decoder: run-length packets to positioned color runs
// ----------------------------------------------------------------------------
// The block takes one data byte per clock whenever full is low and hands out
// at most one run result per byte. The front end parses packet headers,
// gathers pixel bytes and positions each run, updating its column and row
// counts as each event is emitted; it writes positioned events into a
// QUEUE_DEPTH entry event queue. The back end converts pixel formats and, for
// colour formats, divides the channel sum by three, writing a two entry result
// queue that drives the output ports. A result passes through the event queue
// and then the result queue before it reaches the outputs. full rises only
// when the event queue is full, so a stalled consumer stops input after the
// queues fill. No reset sweep is needed. Configuration is written through
// cfg_we, cfg_index and cfg_data and takes effect at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tga_pixel_stream_decoder_core #(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned MAX_HEIGHT  = 4096,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  // byte requests
  input  logic                              push,
  output logic                              full,
  input  logic                              action,
  input  logic [7:0]                        data_byte,
  // run results
  output logic                              empty,
  input  logic                              pop,
  output logic [11:0]                       x_first,
  output logic [11:0]                       y_row,
  output logic [7:0]                        run_length,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue,
  output logic [7:0]                        alpha,
  output logic [7:0]                        luminance,
  output logic                              run_clipped,
  output logic                              last_pixel,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [tgapd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tgapd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tgapd_pkg::*;

  localparam int unsigned EVT_W = $bits(evt_t);
  localparam int unsigned RES_W = $bits(res_t);

  cfg_t  cfg;
  logic  take;
  logic  evt_valid;
  evt_t  evt_in;
  evt_t  evt_head;
  logic  evt_full;
  logic  evt_empty;
  logic  move;
  res_t  res_in;
  res_t  res_head;
  logic  res_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_bytes    <= 3'd4;
      cfg.rle_packed     <= 1'b0;
      cfg.image_width    <= 13'd256;
      cfg.image_height   <= 13'd256;
      cfg.mirror_columns <= 1'b0;
      cfg.rows_top_down  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_BYTES:    cfg.pixel_bytes    <= cfg_data[2:0];
        REG_RLE_PACKED:     cfg.rle_packed     <= cfg_data[0];
        REG_IMAGE_WIDTH:    cfg.image_width    <= cfg_data;
        REG_IMAGE_HEIGHT:   cfg.image_height   <= cfg_data;
        REG_MIRROR_COLUMNS: cfg.mirror_columns <= cfg_data[0];
        REG_ROWS_TOP_DOWN:  cfg.rows_top_down  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front end: one byte request per cycle while the event queue has room
  assign full = evt_full;
  assign take = push && !evt_full;

  tgapd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .action    (action),
    .data_byte (data_byte),
    .evt_valid (evt_valid),
    .evt       (evt_in)
  );

  // decoupling queue between parsing and conversion
  tgapd_fifo #(
    .WIDTH (EVT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_evt_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (evt_valid),
    .wr_data (evt_in),
    .rd_en   (move),
    .rd_data (evt_head),
    .full    (evt_full),
    .empty   (evt_empty)
  );

  // back end: convert the oldest event when the result queue has room
  assign move = !evt_empty && !res_full;

  tgapd_back u_back (
    .evt (evt_head),
    .res (res_in)
  );

  tgapd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (move),
    .wr_data (res_in),
    .rd_en   (pop && !empty),
    .rd_data (res_head),
    .full    (res_full),
    .empty   (empty)
  );

  assign x_first     = res_head.x_first;
  assign y_row       = res_head.y_row;
  assign run_length  = res_head.run_length;
  assign red         = res_head.red;
  assign green       = res_head.green;
  assign blue        = res_head.blue;
  assign alpha       = res_head.alpha;
  assign luminance   = res_head.luminance;
  assign run_clipped = res_head.run_clipped;
  assign last_pixel  = res_head.last_pixel;

  // an event can only be produced by an accepted byte
  `TGAPD_NEVER(a_evt_without_take, clk, rst, evt_valid && !take, "event without a byte request")
  // a produced event always lands in a queue with room
  `TGAPD_NEVER(a_evt_overflow, clk, rst, evt_valid && evt_full, "event queue overflow")
  // every visible result covers at least one column
  `TGAPD_ASSERT(a_len_nonzero, clk, rst, !empty |-> (run_length != 8'd0), "zero length run")

endmodule
